/* src/tssr_pkg.sv */
// ----------------------------------------------------------------------------
// tssr_pkg
// Shared constants, types and helpers of the tag scoped substring replacer.
// ----------------------------------------------------------------------------
package tssr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int PAT_W       = 64;
  localparam int LEN_W       = 4;
  localparam int VAL_W       = 32;
  localparam int BCD_DIGITS  = 10;
  localparam int NUM_STR     = BCD_DIGITS + 1;
  localparam int QUEUE_DEPTH = NUM_STR + 1;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_VALUE = 2'd2;

  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  typedef logic [NUM_STR-1:0][7:0] num_str_t;

  // per word control shared by all window cells
  typedef struct packed {
    logic       step;
    logic       shift;
    logic [7:0] in_byte;
  } win_ctl_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      r = c + CASE_GAP;
    end
    return r;
  endfunction

endpackage

/* src/tssr_win_cell.sv */
// ----------------------------------------------------------------------------
// tssr_win_cell
// One byte of the sliding window: loads, shifts towards the head, compares.
// ----------------------------------------------------------------------------
module tssr_win_cell (
  input  logic               clk_i,
  input  tssr_pkg::win_ctl_t ctl_i,
  input  logic               push_i,
  input  logic               in_use_i,
  input  logic [7:0]         pat_i,
  input  logic [7:0]         nbr_i,
  output logic [7:0]         eff_o,
  output logic               match_o
);

  logic [7:0] byte_q;

  // byte as seen after the incoming word has been written in
  assign eff_o   = push_i ? ctl_i.in_byte : byte_q;
  assign match_o = !in_use_i || (tssr_pkg::fold(eff_o) == tssr_pkg::fold(pat_i));

  always_ff @(posedge clk_i) begin
    if (ctl_i.step) begin
      byte_q <= ctl_i.shift ? nbr_i : eff_o;
    end
  end

endmodule

/* src/tssr_bcd_cell.sv */
// ----------------------------------------------------------------------------
// tssr_bcd_cell
// One decimal digit of a shift and add-3 binary to decimal converter.
// ----------------------------------------------------------------------------
module tssr_bcd_cell (
  input  logic       clk_i,
  input  logic       clr_i,
  input  logic       step_i,
  input  logic       carry_i,
  output logic       carry_o,
  output logic [3:0] digit_o
);

  logic [3:0] digit_q;
  logic [3:0] adj;

  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      digit_q <= 4'd0;
    end else if (step_i) begin
      digit_q <= {adj[2:0], carry_i};
    end
  end

endmodule

/* src/tssr_num_conv.sv */
// ----------------------------------------------------------------------------
// tssr_num_conv
// Turns the replacement value into its signed decimal text, once per write.
// ----------------------------------------------------------------------------
module tssr_num_conv (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic [tssr_pkg::VAL_W-1:0]     value_i,
  output logic                           ready_o,
  output tssr_pkg::num_str_t             str_o,
  output logic [3:0]                     len_o
);

  localparam int ND = tssr_pkg::BCD_DIGITS;
  localparam int SW = $clog2(tssr_pkg::VAL_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FORMAT
  } state_e;

  state_e                     state_q;
  logic [SW-1:0]              step_q;
  logic [tssr_pkg::VAL_W-1:0] mag_q;
  logic                       neg_q;
  tssr_pkg::num_str_t         str_q;
  logic [3:0]                 len_q;

  logic [ND:0]     carry;
  logic [ND-1:0][3:0] digit;
  tssr_pkg::num_str_t str_d;
  logic [3:0]      len_d;

  assign carry[0] = mag_q[tssr_pkg::VAL_W-1];

  for (genvar d = 0; d < ND; d++) begin : g_digit
    tssr_bcd_cell u_cell (
      .clk_i   (clk_i),
      .clr_i   (load_i),
      .step_i  (state_q == ST_SHIFT),
      .carry_i (carry[d]),
      .carry_o (carry[d+1]),
      .digit_o (digit[d])
    );
  end

  // strip leading zeros and put the sign in front
  always_comb begin
    logic [3:0] lz;
    logic [3:0] nd;
    logic       found;
    logic [ND-1:0][3:0] dl;
    lz    = 4'd0;
    found = 1'b0;
    for (int d = ND - 1; d > 0; d--) begin
      if (!found && digit[d] == 4'd0) begin
        lz = lz + 4'd1;
      end else begin
        found = 1'b1;
      end
    end
    nd = 4'(ND) - lz;
    for (int q = 0; q < ND; q++) begin
      dl[q] = 4'd0;
      for (int s = 0; s < ND; s++) begin
        if (int'(lz) + q + s == ND - 1) begin
          dl[q] = digit[s];
        end
      end
    end
    for (int p = 0; p < tssr_pkg::NUM_STR; p++) begin
      str_d[p] = 8'h00;
      if (neg_q) begin
        if (p == 0) begin
          str_d[p] = tssr_pkg::CHAR_MINUS;
        end else if (p - 1 < int'(nd)) begin
          str_d[p] = tssr_pkg::CHAR_ZERO + {4'd0, dl[p-1]};
        end
      end else if (p < ND && p < int'(nd)) begin
        str_d[p] = tssr_pkg::CHAR_ZERO + {4'd0, dl[p]};
      end
    end
    len_d = nd + {3'd0, neg_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      str_q   <= {{(tssr_pkg::NUM_STR-1){8'h00}}, tssr_pkg::CHAR_ZERO};
      len_q   <= 4'd1;
    end else if (load_i) begin
      state_q <= ST_SHIFT;
      step_q  <= '0;
      neg_q   <= value_i[tssr_pkg::VAL_W-1];
      mag_q   <= value_i[tssr_pkg::VAL_W-1] ? ~value_i + 1'b1 : value_i;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
        end
        ST_SHIFT: begin
          mag_q  <= {mag_q[tssr_pkg::VAL_W-2:0], 1'b0};
          step_q <= step_q + 1'b1;
          if (step_q == SW'(tssr_pkg::VAL_W - 1)) begin
            state_q <= ST_FORMAT;
          end
        end
        ST_FORMAT: begin
          str_q   <= str_d;
          len_q   <= len_d;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign ready_o = (state_q == ST_IDLE) && !load_i;
  assign str_o   = str_q;
  assign len_o   = len_q;

endmodule

/* src/tag_scoped_substring_replace.sv */
// ----------------------------------------------------------------------------
// tag_scoped_substring_replace
// Replaces a case folded pattern found inside tags by a decimal number.
// ----------------------------------------------------------------------------
// Input words arrive on the s_axis channel: one text byte per word, tuser set
// when the byte is present, tlast closing the line. Output words leave on the
// m_axis channel, one byte each; tlast marks the final byte caused by an input
// word. The bytes of an accepted input word appear on m_axis from the next
// cycle on, one per cycle while m_axis_tready is high, and then a word that
// causes a single byte lets the next word in every cycle; a match (sign and
// up to ten digits) or an end-of-line flush (window plus newline) holds
// s_axis_tready low until the single output queue, draining one byte a
// cycle, is down to its last byte. When m_axis_tready is low the queue
// holds and s_axis_tready drops once the last queued byte is waiting.
// Writing the replacement value starts a decimal conversion in the digit
// chain (shift, then format); s_axis_tready stays low until it completes.
// After reset the window is empty, the tag flag clear, the pattern is one
// zero byte and the replacement prints as 0.
module tag_scoped_substring_replace #(
  parameter int MAX_PATTERN = tssr_pkg::MAX_PATTERN
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // char_byte
  input  logic                               s_axis_tuser,  // has_char
  input  logic                               s_axis_tlast,  // end_of_line
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // out_byte
  output logic                               m_axis_tlast,  // last_in_run
  input  logic                               cfg_we_i,
  input  logic [tssr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tssr_pkg::PAT_W-1:0]         cfg_data_i
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int QD = tssr_pkg::QUEUE_DEPTH;
  localparam int QW = $clog2(QD + 1);

  logic [tssr_pkg::PAT_W-1:0] pat_q;
  logic [tssr_pkg::LEN_W-1:0] plen_q;
  logic [CW-1:0]              cnt_q;
  logic                       tag_q;
  logic [QD-1:0][7:0]         qbyte_q;
  logic [QW-1:0]              qcnt_q;

  logic               conv_ready;
  tssr_pkg::num_str_t num_str;
  logic [3:0]         num_len;

  logic                        in_acc;
  logic                        out_acc;
  tssr_pkg::win_ctl_t          ctl;
  logic [MAX_PATTERN-1:0]      push_here;
  logic [MAX_PATTERN-1:0]      in_use;
  logic [MAX_PATTERN-1:0]      match;
  logic [MAX_PATTERN-1:0][7:0] eff;
  logic [MAX_PATTERN-1:0][7:0] nbr;

  logic [CW-1:0]      len;
  logic               push;
  logic [CW-1:0]      cnt1;
  logic [CW-1:0]      cnt2;
  logic               judge;
  logic               flag1;
  logic               hit;
  logic               shift;
  logic [3:0]         len_a;
  logic [QD-1:0][7:0] lst;
  logic [QW-1:0]      lst_n;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      plen_q <= tssr_pkg::LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tssr_pkg::REG_PATTERN_BYTES:  pat_q  <= cfg_data_i;
        tssr_pkg::REG_PATTERN_LENGTH: plen_q <= cfg_data_i[tssr_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tssr_num_conv u_num_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (cfg_we_i && cfg_idx_i == tssr_pkg::REG_REPLACEMENT_VALUE),
    .value_i (cfg_data_i[tssr_pkg::VAL_W-1:0]),
    .ready_o (conv_ready),
    .str_o   (num_str),
    .len_o   (num_len)
  );

  assign s_axis_tready = conv_ready &&
                         (qcnt_q == '0 || (qcnt_q == QW'(1) && m_axis_tready));
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    if (plen_q == '0) begin
      len = CW'(1);
    end else if (plen_q > tssr_pkg::LEN_W'(MAX_PATTERN)) begin
      len = CW'(MAX_PATTERN);
    end else begin
      len = CW'(plen_q);
    end
  end

  assign push = s_axis_tuser && (cnt_q < CW'(MAX_PATTERN));
  assign cnt1 = push ? cnt_q + 1'b1 : cnt_q;

  assign ctl.step    = in_acc && s_axis_tuser;
  assign ctl.shift   = shift;
  assign ctl.in_byte = s_axis_tdata;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_win
    assign push_here[k] = push && (cnt_q == CW'(k));
    assign in_use[k]    = CW'(k) < len;
    if (k + 1 < MAX_PATTERN) begin : g_mid
      assign nbr[k] = eff[k+1];
    end else begin : g_end
      assign nbr[k] = 8'h00;
    end
    tssr_win_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .push_i   (push_here[k]),
      .in_use_i (in_use[k]),
      .pat_i    (pat_q[8*k +: 8]),
      .nbr_i    (nbr[k]),
      .eff_o    (eff[k]),
      .match_o  (match[k])
    );
  end

  // head judged once the window is full
  always_comb begin
    judge = s_axis_tuser && (cnt1 >= len);
    flag1 = tag_q;
    if (judge && eff[0] == tssr_pkg::CHAR_LT) begin
      flag1 = 1'b1;
    end
    if (judge && eff[0] == tssr_pkg::CHAR_GT) begin
      flag1 = 1'b0;
    end
    hit   = judge && (cnt1 == len) && flag1 && (&match);
    shift = judge && !hit;
    if (hit) begin
      cnt2 = '0;
    end else if (shift) begin
      cnt2 = cnt1 - 1'b1;
    end else begin
      cnt2 = cnt1;
    end
  end

  // build the bytes caused by this word: number or head, then flush and newline
  always_comb begin
    logic [4:0] total;
    len_a = hit ? num_len : (shift ? 4'd1 : 4'd0);
    for (int j = 0; j < QD; j++) begin
      lst[j] = 8'h00;
      if (hit && j < tssr_pkg::NUM_STR && j < int'(num_len)) begin
        lst[j] = num_str[j];
      end
      if (shift && j == 0) begin
        lst[j] = eff[0];
      end
      if (s_axis_tlast) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
          if (5'(j) == 5'(len_a) + 5'(i) && CW'(i) < cnt2) begin
            lst[j] = shift ? nbr[i] : eff[i];
          end
        end
        if (5'(j) == 5'(len_a) + 5'(cnt2)) begin
          lst[j] = tssr_pkg::CHAR_NL;
        end
      end
    end
    total = 5'(len_a);
    if (s_axis_tlast) begin
      total = total + 5'(cnt2) + 5'd1;
    end
    lst_n = QW'(total);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      tag_q  <= 1'b0;
      qcnt_q <= '0;
    end else begin
      if (in_acc) begin
        cnt_q  <= s_axis_tlast ? '0 : cnt2;
        tag_q  <= s_axis_tlast ? 1'b0 : flag1;
        qcnt_q <= lst_n;
      end else if (out_acc) begin
        qcnt_q <= qcnt_q - 1'b1;
      end
    end
  end

  // output queue: loaded whole, drained from slot zero
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      qbyte_q <= lst;
    end else if (out_acc) begin
      for (int j = 0; j < QD - 1; j++) begin
        qbyte_q[j] <= qbyte_q[j+1];
      end
      qbyte_q[QD-1] <= 8'h00;
    end
  end

  assign m_axis_tvalid = qcnt_q != '0;
  assign m_axis_tdata  = qbyte_q[0];
  assign m_axis_tlast  = qcnt_q == QW'(1);

endmodule
